// ===== hw/rtl/itil_pkg.sv =====
// itil_pkg: shared widths, codes, state types and status structs for the
// inverse table interpolation lookup. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itil_pkg;

	localparam int DEF_TABLE_DEPTH = 1024;

	localparam int X_W     = 32;
	localparam int Y_W     = 31;
	localparam int IDX_W   = 10;
	localparam int EU_W    = 11;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// product of |q - y_low| (31 bits) and |x_high - x_low| (32 bits)
	localparam int PROD_W    = 63;
	localparam int DIV_STEPS = PROD_W;
	localparam int DCNT_W    = 6;
	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);

	// quotient clamp of 2^33 and the sum range
	localparam int QMAG_W = 34;
	localparam int SUM_W  = 35;
	localparam logic [QMAG_W-1:0] QUO_LIMIT = 34'h2_0000_0000;
	localparam logic signed [SUM_W-1:0] SUM_MAX = 35'sd2147483647;
	localparam logic signed [SUM_W-1:0] SUM_MIN = -35'sd2147483648;

	localparam logic [Y_W-1:0] MAX_ENERGY_RST = 31'd1048576;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic REG_ENTRIES_USED = 1'b0;
	localparam logic REG_MAX_ENERGY   = 1'b1;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_SCAN,
		TS_INTERP
	} top_state_t;

	typedef enum logic [1:0] {
		IS_IDLE,
		IS_MUL,
		IS_DIV,
		IS_FIX
	} interp_state_t;

	typedef struct packed {
		logic signed [X_W-1:0] xl;
		logic signed [X_W-1:0] xh;
		logic [Y_W-1:0]        yl;
		logic [Y_W-1:0]        yh;
	} bracket_t;

	typedef struct packed {
		logic active;
		logic done;
		logic hit;
	} scan_status_t;

	typedef struct packed {
		logic active;
		logic done;
	} interp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/itil_ram.sv =====
// itil_ram: generic single-port synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module itil_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/itil_scan.sv =====
// itil_scan: walks the table one entry per cycle through the RAM read port and
// finds the first entry past index 0 whose integral exceeds the target.
// Depends on itil_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itil_scan #(
	parameter int TABLE_DEPTH = itil_pkg::DEF_TABLE_DEPTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               go,
	input  wire logic [itil_pkg::Y_W-1:0]           q,
	input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]   n,
	output logic      [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
	input  wire logic [itil_pkg::X_W-1:0]           rd_x,
	input  wire logic [itil_pkg::Y_W-1:0]           rd_y,
	output itil_pkg::scan_status_t                  status,
	output itil_pkg::bracket_t                      bracket
);

	import itil_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic           active_q;
	logic           pend_s1;
	logic           done_q;
	logic           hit_q;
	logic [CW-1:0]  addr_q;
	logic [CW-1:0]  idx_s1;
	logic [X_W-1:0] prev_x_q;
	logic [Y_W-1:0] prev_y_q;
	bracket_t       br_q;

	logic issue;
	logic is_hit;
	logic is_last;
	logic finish;
	logic too_short;

	always_comb begin
		issue     = active_q && (addr_q < n);
		is_hit    = pend_s1 && (idx_s1 != '0) && (rd_y > q);
		is_last   = pend_s1 && (idx_s1 == n - CW'(1));
		finish    = is_hit || is_last;
		too_short = n < CW'(2);
	end

	assign rd_addr = addr_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pend_s1  <= 1'b0;
			done_q   <= 1'b0;
			hit_q    <= 1'b0;
			addr_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				active_q <= !too_short;
				pend_s1  <= 1'b0;
				done_q   <= too_short;
				hit_q    <= 1'b0;
				addr_q   <= '0;
			end else if (active_q) begin
				if (finish) begin
					active_q <= 1'b0;
					pend_s1  <= 1'b0;
					done_q   <= 1'b1;
					hit_q    <= is_hit;
				end else begin
					pend_s1 <= issue;
					if (issue) begin
						addr_q <= addr_q + CW'(1);
					end
				end
			end
		end
	end

	// read data comes back in the cycle after its address; keep the previous entry
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= addr_q;
		end
		if (pend_s1) begin
			prev_x_q <= rd_x;
			prev_y_q <= rd_y;
		end
		if (active_q && is_hit) begin
			br_q.xl <= $signed(prev_x_q);
			br_q.xh <= $signed(rd_x);
			br_q.yl <= prev_y_q;
			br_q.yh <= rd_y;
		end
	end

	assign status.active = active_q;
	assign status.done   = done_q;
	assign status.hit    = hit_q;
	assign bracket       = br_q;

endmodule

`default_nettype wire

// ===== hw/rtl/itil_interp.sv =====
// itil_interp: linear interpolation between two bracket points; one multiply,
// a bit-serial restoring divide, then clamp and saturating add; a zero divisor skips the divide and gives x_low.
// Depends on itil_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itil_interp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [itil_pkg::Y_W-1:0]    q,
	input  itil_pkg::bracket_t               br,
	output itil_pkg::interp_status_t         status,
	output logic signed [itil_pkg::X_W-1:0]  result
);

	import itil_pkg::*;

	interp_state_t state_q;
	interp_state_t state_d;

	logic ld_ops;
	logic do_mul;
	logic do_div;
	logic do_fix;

	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;

	logic signed [X_W:0]   dq_q;
	logic signed [X_W:0]   dx_q;
	logic signed [Y_W:0]   dy_q;
	logic signed [X_W-1:0] xl_q;
	logic [PROD_W-1:0]     work_q;
	logic [Y_W-1:0]        rem_q;
	logic [Y_W-1:0]        dvs_q;
	logic                  neg_q;
	logic                  zdiv_q;
	logic signed [X_W-1:0] result_q;

	logic signed [X_W:0]   dq_abs;
	logic signed [X_W:0]   dx_abs;
	logic signed [Y_W:0]   dy_abs;
	logic [PROD_W-1:0]     prod;
	logic                  dy_zero;
	logic [Y_W:0]          trial;
	logic [Y_W:0]          trial_diff;
	logic                  trial_ge;
	logic [QMAG_W-1:0]     qmag;
	logic signed [SUM_W-1:0] quo;
	logic signed [SUM_W-1:0] sum;
	logic signed [X_W-1:0] sat;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			IS_IDLE: if (go) state_d = IS_MUL;
			IS_MUL:  state_d = dy_zero ? IS_FIX : IS_DIV;
			IS_DIV:  if (cnt_q == DIV_LAST) state_d = IS_FIX;
			IS_FIX:  state_d = IS_IDLE;
			default: state_d = IS_IDLE;
		endcase
	end

	always_comb begin
		ld_ops = 1'b0;
		do_mul = 1'b0;
		do_div = 1'b0;
		do_fix = 1'b0;
		unique case (state_q)
			IS_IDLE: ld_ops = go;
			IS_MUL:  do_mul = 1'b1;
			IS_DIV:  do_div = 1'b1;
			IS_FIX:  do_fix = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		dq_abs  = dq_q[X_W] ? -dq_q : dq_q;
		dx_abs  = dx_q[X_W] ? -dx_q : dx_q;
		dy_abs  = dy_q[Y_W] ? -dy_q : dy_q;
		dy_zero = (dy_q == '0);
		prod    = dq_abs[Y_W-1:0] * dx_abs[X_W-1:0];

		trial      = {rem_q, work_q[PROD_W-1]};
		trial_ge   = trial >= {1'b0, dvs_q};
		trial_diff = trial - {1'b0, dvs_q};

		// quotient magnitude clamped to 2^33 before the sign goes back on
		qmag = (work_q > PROD_W'(QUO_LIMIT)) ? QUO_LIMIT : work_q[QMAG_W-1:0];
		quo  = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
		sum  = $signed({{(SUM_W - X_W){xl_q[X_W-1]}}, xl_q}) + quo;
		if (sum > SUM_MAX) begin
			sat = SUM_MAX[X_W-1:0];
		end else if (sum < SUM_MIN) begin
			sat = SUM_MIN[X_W-1:0];
		end else begin
			sat = sum[X_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IS_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= do_fix;
			if (do_mul) begin
				cnt_q <= '0;
			end else if (do_div) begin
				cnt_q <= cnt_q + DCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_ops) begin
			dq_q <= $signed({2'b00, q} - {2'b00, br.yl});
			dx_q <= $signed({br.xh[X_W-1], br.xh} - {br.xl[X_W-1], br.xl});
			dy_q <= $signed({1'b0, br.yh} - {1'b0, br.yl});
			xl_q <= br.xl;
		end
		if (do_mul) begin
			work_q <= prod;
			rem_q  <= '0;
			dvs_q  <= dy_abs[Y_W-1:0];
			neg_q  <= dq_q[X_W] ^ dx_q[X_W] ^ dy_q[Y_W];
			zdiv_q <= dy_zero;
		end
		if (do_div) begin
			work_q <= {work_q[PROD_W-2:0], trial_ge};
			rem_q  <= trial_ge ? trial_diff[Y_W-1:0] : trial[Y_W-1:0];
		end
		if (do_fix) begin
			result_q <= zdiv_q ? xl_q : sat;
		end
	end

	assign status.active = (state_q != IS_IDLE);
	assign status.done   = done_q;
	assign result        = result_q;

endmodule

`default_nettype wire

// ===== hw/rtl/inverse_table_interpolation_lookup.sv =====
// inverse_table_interpolation_lookup: top level with register port, control
// sequencer, table RAMs, scan unit and interpolation unit.
// Depends on itil_pkg, itil_ram, itil_scan, itil_interp.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+---------------------------------------
//  request  | start, busy (beat: start&!busy) | req_type entry_index entry_x entry_y
//           |                                | query_value
//  result   | done (one-cycle strobe)        | result_x overflow bracket_low_x/high_x
//           |                                | bracket_low_y/high_y
//  config   | psel penable pwrite, pready=1  | paddr pwdata prdata
//
// a table write never raises busy
// a negative query gives its result in the cycle after the beat
// other queries scan the table, reading k entries (at most the clamped
// entries_used, one RAM read per cycle), then on a hit interpolate with a
// multiply and the 63-step serial divide; zero divisor skips the divide
// after reset the table contents are undefined until written
// results cannot be stalled; done lasts exactly one cycle
`timescale 1ns / 1ps
`default_nettype none

module inverse_table_interpolation_lookup #(
	parameter int TABLE_DEPTH = itil_pkg::DEF_TABLE_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [itil_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [itil_pkg::PDATA_W-1:0]      pwdata,
	output logic      [itil_pkg::PDATA_W-1:0]      prdata,
	output logic                                   pready,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              req_type,
	input  wire logic [itil_pkg::IDX_W-1:0]        entry_index,
	input  wire logic signed [itil_pkg::X_W-1:0]   entry_x,
	input  wire logic [itil_pkg::Y_W-1:0]          entry_y,
	input  wire logic signed [itil_pkg::X_W-1:0]   query_value,
	output logic                                   done,
	output logic signed [itil_pkg::X_W-1:0]        result_x,
	output logic                                   overflow,
	output logic signed [itil_pkg::X_W-1:0]        bracket_low_x,
	output logic signed [itil_pkg::X_W-1:0]        bracket_high_x,
	output logic      [itil_pkg::Y_W-1:0]          bracket_low_y,
	output logic      [itil_pkg::Y_W-1:0]          bracket_high_y
);

	import itil_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// configuration registers
	logic [EU_W-1:0] entries_used_q;
	logic [Y_W-1:0]  max_energy_q;
	logic            cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_used_q <= '0;
			max_energy_q   <= MAX_ENERGY_RST;
		end else if (cfg_we) begin
			unique case (paddr[2])
				REG_ENTRIES_USED: entries_used_q <= pwdata[EU_W-1:0];
				REG_MAX_ENERGY:   max_energy_q   <= pwdata[Y_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ENTRIES_USED: prdata = {{(PDATA_W - EU_W){1'b0}}, entries_used_q};
			REG_MAX_ENERGY:   prdata = {{(PDATA_W - Y_W){1'b0}}, max_energy_q};
			default:          prdata = '0;
		endcase
	end

	// sequencer
	top_state_t state_q;
	top_state_t state_d;

	scan_status_t   scan_st;
	interp_status_t interp_st;
	bracket_t       scan_br;

	logic accept;
	logic is_query;
	logic in_range;
	logic ram_we;
	logic scan_go;
	logic interp_go;
	logic emit_neg;
	logic emit_miss;
	logic emit_hit;

	logic [Y_W-1:0] q_q;
	logic [CW-1:0]  n_clamp;

	assign busy     = (state_q != TS_IDLE);
	assign accept   = start && !busy;
	assign is_query = (req_type == REQ_QUERY);
	assign in_range = {{(32 - IDX_W){1'b0}}, entry_index} < 32'(TABLE_DEPTH);

	always_comb begin
		if (32'(entries_used_q) > 32'(TABLE_DEPTH)) begin
			n_clamp = CW'(TABLE_DEPTH);
		end else begin
			n_clamp = CW'(entries_used_q);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TS_IDLE:   if (scan_go) state_d = TS_SCAN;
			TS_SCAN:   if (scan_st.done) state_d = scan_st.hit ? TS_INTERP : TS_IDLE;
			TS_INTERP: if (interp_st.done) state_d = TS_IDLE;
			default:   state_d = TS_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		scan_go   = 1'b0;
		emit_neg  = 1'b0;
		emit_miss = 1'b0;
		interp_go = 1'b0;
		emit_hit  = 1'b0;
		unique case (state_q)
			TS_IDLE: begin
				ram_we   = accept && !is_query && in_range;
				scan_go  = accept && is_query && !query_value[X_W-1];
				emit_neg = accept && is_query && query_value[X_W-1];
			end
			TS_SCAN: begin
				emit_miss = scan_st.done && !scan_st.hit;
				interp_go = scan_st.done && scan_st.hit;
			end
			TS_INTERP: begin
				emit_hit = interp_st.done;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_go) begin
			q_q <= query_value[Y_W-1:0];
		end
	end

	// table memories
	logic [AW-1:0]  ram_addr;
	logic [AW-1:0]  scan_addr;
	logic [X_W-1:0] rd_x;
	logic [Y_W-1:0] rd_y;

	assign ram_addr = busy ? scan_addr : AW'(entry_index);

	itil_ram #(
		.WIDTH (X_W),
		.DEPTH (TABLE_DEPTH)
	) u_x_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (entry_x),
		.rdata (rd_x)
	);

	itil_ram #(
		.WIDTH (Y_W),
		.DEPTH (TABLE_DEPTH)
	) u_y_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (entry_y),
		.rdata (rd_y)
	);

	itil_scan #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (scan_go),
		.q       (q_q),
		.n       (n_clamp),
		.rd_addr (scan_addr),
		.rd_x    (rd_x),
		.rd_y    (rd_y),
		.status  (scan_st),
		.bracket (scan_br)
	);

	logic signed [X_W-1:0] interp_result;

	itil_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (interp_go),
		.q      (q_q),
		.br     (scan_br),
		.status (interp_st),
		.result (interp_result)
	);

	// result registers
	logic                  done_q;
	logic signed [X_W-1:0] result_x_q;
	logic                  overflow_q;
	logic signed [X_W-1:0] low_x_q;
	logic signed [X_W-1:0] high_x_q;
	logic [Y_W-1:0]        low_y_q;
	logic [Y_W-1:0]        high_y_q;
	logic signed [X_W-1:0] sat_pos;

	assign sat_pos = $signed({1'b0, max_energy_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit_neg || emit_miss || emit_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_neg) begin
			result_x_q <= -sat_pos;
			overflow_q <= 1'b1;
			low_x_q    <= -sat_pos;
			high_x_q   <= -sat_pos;
			low_y_q    <= '0;
			high_y_q   <= '0;
		end else if (emit_miss) begin
			result_x_q <= sat_pos;
			overflow_q <= 1'b1;
			low_x_q    <= sat_pos;
			high_x_q   <= sat_pos;
			low_y_q    <= '0;
			high_y_q   <= '0;
		end else if (emit_hit) begin
			result_x_q <= interp_result;
			overflow_q <= 1'b0;
			low_x_q    <= scan_br.xl;
			high_x_q   <= scan_br.xh;
			low_y_q    <= scan_br.yl;
			high_y_q   <= scan_br.yh;
		end
	end

	assign done           = done_q;
	assign result_x       = result_x_q;
	assign overflow       = overflow_q;
	assign bracket_low_x  = low_x_q;
	assign bracket_high_x = high_x_q;
	assign bracket_low_y  = low_y_q;
	assign bracket_high_y = high_y_q;

	// an interpolated result always lies under a right bracket above the target
	a_hit_above_target: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !overflow) |-> (bracket_high_y > q_q))
		else $error("interpolated result with right bracket not above target");

	a_scan_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == TS_SCAN) |-> (scan_st.active || scan_st.done))
		else $error("sequencer waits on an idle scan unit");

	a_interp_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == TS_INTERP) |-> (interp_st.active || interp_st.done))
		else $error("sequencer waits on an idle interpolation unit");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(scan_st.active && interp_st.active))
		else $error("scan and interpolation active together");

endmodule

`default_nettype wire
